/* sv/gradient_aggregate_weight_update_core_assert.svh */
// Assertion macros for the checker file.
`ifndef GRADIENT_AGGREGATE_WEIGHT_UPDATE_CORE_ASSERT_SVH
`define GRADIENT_AGGREGATE_WEIGHT_UPDATE_CORE_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define GAWU_ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define GAWU_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

/* sv/gawu_pkg.sv */
// Types and constants of the weight store core.
`timescale 1ns / 1ps
`default_nettype none
package gawu_pkg;

  localparam int OP_W       = 2;
  localparam int KEY_W      = 10;
  localparam int VAL_W      = 32;
  localparam int CNT_W      = 7;
  localparam int COEF_W     = 16;
  localparam int LEN_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;

  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_PULL = 2'd1;

  localparam logic KIND_PULL = 1'b0;
  localparam logic KIND_ACK  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_WORKERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHRINK  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 2'd3;

  localparam logic [CNT_W-1:0]  WORKERS_RST = 7'd1;
  localparam logic [COEF_W-1:0] STEP_RST    = 16'd9830;
  localparam logic [COEF_W-1:0] SHRINK_RST  = 16'd66;
  localparam logic [LEN_W-1:0]  LENGTH_RST  = 11'd1024;

  // norm: sum of squares, square root one result bit per step
  localparam int SUM_W      = 80;
  localparam int RAD_W      = 82;
  localparam int ROOT_W     = 41;
  localparam int REM_W      = 44;
  localparam int SQRT_STEPS = 41;
  // shrink term: restoring divide one quotient bit per step
  localparam int PROD_W     = 49;
  localparam int NUM_W      = 49;
  localparam int DEN_W      = 42;
  localparam int DREM_W     = 43;
  localparam int DIV_STEPS  = 49;
  localparam int ITC_W      = 6;
  localparam int WIDE_W     = 51;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PUSH_WR,
    ST_PULL_OUT,
    ST_ACK_OUT,
    ST_NORM_RD,
    ST_NORM_WAIT,
    ST_SQRT,
    ST_UPD_RD,
    ST_UPD_MUL,
    ST_UPD_RND,
    ST_UPD_W1,
    ST_UPD_LMUL,
    ST_UPD_DIVI,
    ST_UPD_DIV,
    ST_UPD_W2,
    ST_UPD_WR
  } state_e;

  typedef enum logic [1:0] {
    RD_INPUT,
    RD_HELD,
    RD_INDEX
  } rd_sel_e;

  typedef struct packed {
    logic    accept;
    rd_sel_e rd_sel;
    logic    grad_push;
    logic    cnt_inc;
    logic    cnt_clr;
    logic    idx_clr;
    logic    idx_inc;
    logic    clr_wr;
    logic    norm_clr;
    logic    norm_issue;
    logic    sqrt_start;
    logic    sqrt_step;
    logic    upd_mul;
    logic    upd_rnd;
    logic    upd_w1;
    logic    upd_lmul;
    logic    div_start;
    logic    div_step;
    logic    upd_w2;
    logic    upd_wr;
    logic    out_pull;
    logic    out_ack;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic idx_active;
    logic norm_end;
    logic pipe_busy;
    logic sqrt_done;
    logic div_done;
    logic norm_zero;
    logic last;
    logic due;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

/* sv/gawu_ram.sv */
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module gawu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  wire logic [WIDTH-1:0]                 wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic      [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

/* sv/gawu_dp.sv */
// Datapath: stores, config registers, norm pipe, square root, divider, output register.
`timescale 1ns / 1ps
`default_nettype none
module gawu_dp #(
  parameter int MAX_LENGTH = 1024
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire gawu_pkg::cmd_t                    cmd_i,
  output gawu_pkg::sts_t                         sts_o,
  input  wire logic [gawu_pkg::IN_DATA_W-1:0]    s_tdata_i,
  input  wire logic                              s_tlast_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [gawu_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [gawu_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                              m_tready_i,
  output logic                                   m_tvalid_o,
  output logic      [gawu_pkg::OUT_DATA_W-1:0]   m_tdata_o,
  output logic                                   m_tuser_o,
  output logic                                   m_tlast_o
);

  localparam int AW  = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int LW  = $clog2(MAX_LENGTH + 1);
  localparam int CW  = (LW > gawu_pkg::LEN_W) ? LW : gawu_pkg::LEN_W;
  localparam int PAD = gawu_pkg::OUT_DATA_W - gawu_pkg::KEY_W - gawu_pkg::VAL_W;
  localparam int WW  = gawu_pkg::WIDE_W;
  localparam logic signed [WW-1:0] SAT_MAX = 51'sd2147483647;
  localparam logic signed [WW-1:0] SAT_MIN = -51'sd2147483648;

  function automatic logic [31:0] sat32(input logic signed [WW-1:0] v);
    logic [31:0] r;
    if (v > SAT_MAX) r = 32'h7FFF_FFFF;
    else if (v < SAT_MIN) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // configuration
  logic [gawu_pkg::CNT_W-1:0]  workers_q;
  logic [gawu_pkg::COEF_W-1:0] step_q, shrink_q;
  logic [gawu_pkg::LEN_W-1:0]  length_q;
  logic [CW-1:0]               eff_len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      workers_q <= gawu_pkg::WORKERS_RST;
      step_q    <= gawu_pkg::STEP_RST;
      shrink_q  <= gawu_pkg::SHRINK_RST;
      length_q  <= gawu_pkg::LENGTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gawu_pkg::CFG_WORKERS: workers_q <= cfg_data_i[gawu_pkg::CNT_W-1:0];
        gawu_pkg::CFG_STEP:    step_q    <= cfg_data_i;
        gawu_pkg::CFG_SHRINK:  shrink_q  <= cfg_data_i;
        gawu_pkg::CFG_LENGTH:  length_q  <= cfg_data_i[gawu_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign eff_len = (CW'(length_q) > CW'(MAX_LENGTH)) ? CW'(MAX_LENGTH) : CW'(length_q);

  // held input item
  logic [gawu_pkg::KEY_W-1:0] in_key, key_q;
  logic [gawu_pkg::VAL_W-1:0] in_val, val_q;
  logic                       last_q, inrng_q;

  assign in_key = s_tdata_i[gawu_pkg::KEY_W-1:0];
  assign in_val = s_tdata_i[gawu_pkg::KEY_W +: gawu_pkg::VAL_W];

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      key_q   <= in_key;
      val_q   <= in_val;
      last_q  <= s_tlast_i;
      inrng_q <= CW'(in_key) < eff_len;
    end
  end

  // sweep index and push counter
  logic [AW-1:0]              idx_q;
  logic [gawu_pkg::CNT_W-1:0] cnt_q, cnt_inc;

  assign cnt_inc = cnt_q + gawu_pkg::CNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.idx_clr) idx_q <= '0;
      else if (cmd_i.idx_inc) idx_q <= idx_q + AW'(1);
      if (cmd_i.cnt_clr) cnt_q <= '0;
      else if (cmd_i.cnt_inc) cnt_q <= cnt_inc;
    end
  end

  // stores
  logic [AW-1:0]              raddr, g_waddr;
  logic [gawu_pkg::VAL_W-1:0] g_rd, w_rd, g_wdata, w_wdata;
  logic                       g_we, w_we, idx_active;
  logic signed [WW-1:0]       psum;

  assign idx_active = CW'(idx_q) < eff_len;

  always_comb begin
    case (cmd_i.rd_sel)
      gawu_pkg::RD_INPUT: raddr = AW'(in_key);
      gawu_pkg::RD_HELD:  raddr = AW'(key_q);
      default:            raddr = idx_q;
    endcase
  end

  assign psum    = WW'($signed(g_rd)) + WW'($signed(val_q));
  assign g_we    = (cmd_i.grad_push && inrng_q) || cmd_i.upd_wr || cmd_i.clr_wr;
  assign g_waddr = cmd_i.grad_push ? AW'(key_q) : idx_q;
  assign g_wdata = cmd_i.grad_push ? sat32(psum) : '0;

  logic [gawu_pkg::VAL_W-1:0] nw_q;

  assign w_we    = (cmd_i.upd_wr && idx_active) || cmd_i.clr_wr;
  assign w_wdata = cmd_i.clr_wr ? '0 : nw_q;

  gawu_ram #(.WIDTH(gawu_pkg::VAL_W), .DEPTH(MAX_LENGTH)) u_grad_ram (
    .clk_i  (clk_i),
    .we_i   (g_we),
    .waddr_i(g_waddr),
    .wdata_i(g_wdata),
    .raddr_i(raddr),
    .rdata_o(g_rd)
  );

  gawu_ram #(.WIDTH(gawu_pkg::VAL_W), .DEPTH(MAX_LENGTH)) u_weight_ram (
    .clk_i  (clk_i),
    .we_i   (w_we),
    .waddr_i(idx_q),
    .wdata_i(w_wdata),
    .raddr_i(raddr),
    .rdata_o(w_rd)
  );

  // sum of squares: read -> magnitude -> square -> accumulate
  logic [2:0]                 nv_q;
  logic [31:0]                mag_q;
  logic [63:0]                sq_q;
  logic [gawu_pkg::SUM_W-1:0] acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) nv_q <= '0;
    else nv_q <= {nv_q[1:0], cmd_i.norm_issue};
  end

  always_ff @(posedge clk_i) begin
    if (nv_q[0]) mag_q <= w_rd[31] ? (~w_rd + 32'd1) : w_rd;
    if (nv_q[1]) sq_q <= mag_q * mag_q;
    if (cmd_i.norm_clr) acc_q <= '0;
    else if (nv_q[2]) acc_q <= acc_q + gawu_pkg::SUM_W'(sq_q);
  end

  // shared step counter for square root and divide
  logic [gawu_pkg::ITC_W-1:0] itc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) itc_q <= '0;
    else if (cmd_i.sqrt_start || cmd_i.div_start) itc_q <= '0;
    else if (cmd_i.sqrt_step || cmd_i.div_step) itc_q <= itc_q + gawu_pkg::ITC_W'(1);
  end

  // square root, two radicand bits per step
  logic [gawu_pkg::RAD_W-1:0]  rad_q;
  logic [gawu_pkg::REM_W-1:0]  rem_q, rem_n, trial;
  logic [gawu_pkg::ROOT_W-1:0] root_q;
  logic                        sq_ge;

  assign rem_n = {rem_q[gawu_pkg::REM_W-3:0], rad_q[gawu_pkg::RAD_W-1 -: 2]};
  assign trial = {1'b0, root_q, 2'b01};
  assign sq_ge = rem_n >= trial;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_start) begin
      rad_q  <= gawu_pkg::RAD_W'(acc_q);
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      rad_q  <= {rad_q[gawu_pkg::RAD_W-3:0], 2'b00};
      rem_q  <= sq_ge ? (rem_n - trial) : rem_n;
      root_q <= {root_q[gawu_pkg::ROOT_W-2:0], sq_ge};
    end
  end

  // per-entry update
  logic signed [16:0]                  eta_s, lam_s;
  logic signed [gawu_pkg::PROD_W-1:0]  prod, prod_q, lprod, lp_q;
  logic [gawu_pkg::PROD_W-2:0]         pmag, lmag;
  logic [31:0]                         rq;
  logic signed [32:0]                  t_q;
  logic [gawu_pkg::VAL_W-1:0]          w_q;
  logic signed [WW-1:0]                diff1, diff2, q_s;

  assign eta_s = $signed({1'b0, step_q});
  assign lam_s = $signed({1'b0, shrink_q});
  assign prod  = eta_s * $signed(g_rd);
  assign lprod = lam_s * $signed(nw_q);
  assign pmag  = prod_q[gawu_pkg::PROD_W-1] ? (gawu_pkg::PROD_W-1)'(-prod_q)
                                            : prod_q[gawu_pkg::PROD_W-2:0];
  assign rq    = 32'((pmag + 48'd32768) >> 16);
  assign diff1 = WW'($signed(w_q)) - WW'(t_q);

  // divide (2|lambda*w1| + norm) by 2*norm
  logic [gawu_pkg::NUM_W-1:0]  dq_q;
  logic [gawu_pkg::DREM_W-1:0] drem_q, drn, den;
  logic                        dv_ge, sneg_q;

  assign lmag  = lp_q[gawu_pkg::PROD_W-1] ? (gawu_pkg::PROD_W-1)'(-lp_q)
                                          : lp_q[gawu_pkg::PROD_W-2:0];
  assign den   = {1'b0, root_q, 1'b0};
  assign drn   = {drem_q[gawu_pkg::DREM_W-2:0], dq_q[gawu_pkg::NUM_W-1]};
  assign dv_ge = drn >= den;
  assign q_s   = sneg_q ? -$signed({2'b00, dq_q}) : $signed({2'b00, dq_q});
  assign diff2 = WW'($signed(nw_q)) - q_s;

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd_mul) begin
      prod_q <= prod;
      w_q    <= w_rd;
    end
    if (cmd_i.upd_rnd) t_q <= prod_q[gawu_pkg::PROD_W-1] ? -$signed({1'b0, rq})
                                                         : $signed({1'b0, rq});
    if (cmd_i.upd_w1) nw_q <= sat32(diff1);
    else if (cmd_i.upd_w2) nw_q <= sat32(diff2);
    if (cmd_i.upd_lmul) lp_q <= lprod;
    if (cmd_i.div_start) begin
      dq_q   <= {lmag, 1'b0} + gawu_pkg::NUM_W'(root_q);
      drem_q <= '0;
      sneg_q <= lp_q[gawu_pkg::PROD_W-1];
    end else if (cmd_i.div_step) begin
      dq_q   <= {dq_q[gawu_pkg::NUM_W-2:0], dv_ge};
      drem_q <= dv_ge ? (drn - den) : drn;
    end
  end

  // output register
  logic                       ov_q, okind_q, olast_q;
  logic [gawu_pkg::KEY_W-1:0] okey_q;
  logic [gawu_pkg::VAL_W-1:0] ow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (cmd_i.out_pull || cmd_i.out_ack) ov_q <= 1'b1;
    else if (m_tready_i) ov_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_pull) begin
      okind_q <= gawu_pkg::KIND_PULL;
      okey_q  <= key_q;
      ow_q    <= inrng_q ? w_rd : '0;
      olast_q <= last_q;
    end else if (cmd_i.out_ack) begin
      okind_q <= gawu_pkg::KIND_ACK;
      okey_q  <= '0;
      ow_q    <= '0;
      olast_q <= 1'b1;
    end
  end

  assign m_tvalid_o = ov_q;
  assign m_tdata_o  = {{PAD{1'b0}}, ow_q, okey_q};
  assign m_tuser_o  = okind_q;
  assign m_tlast_o  = olast_q;

  always_comb begin
    sts_o            = '0;
    sts_o.idx_last   = idx_q == AW'(MAX_LENGTH - 1);
    sts_o.idx_active = idx_active;
    sts_o.norm_end   = (CW'(idx_q) + CW'(1)) >= eff_len;
    sts_o.pipe_busy  = |nv_q;
    sts_o.sqrt_done  = itc_q == gawu_pkg::ITC_W'(gawu_pkg::SQRT_STEPS - 1);
    sts_o.div_done   = itc_q == gawu_pkg::ITC_W'(gawu_pkg::DIV_STEPS - 1);
    sts_o.norm_zero  = root_q == '0;
    sts_o.last       = last_q;
    sts_o.due        = cnt_inc >= workers_q;
    sts_o.out_free   = !ov_q || m_tready_i;
  end

endmodule
`default_nettype wire

/* sv/gawu_ctrl.sv */
// Controller: sequences clearing, requests, norm, square root and update sweep.
`timescale 1ns / 1ps
`default_nettype none
module gawu_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_tvalid_i,
  output logic                               s_tready_o,
  input  wire logic [gawu_pkg::OP_W-1:0]     s_op_i,
  input  wire logic                          s_last_i,
  input  wire gawu_pkg::sts_t                sts_i,
  output gawu_pkg::cmd_t                     cmd_o
);

  gawu_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= gawu_pkg::ST_CLEAR;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      gawu_pkg::ST_CLEAR:
        if (sts_i.idx_last) state_d = gawu_pkg::ST_IDLE;
      gawu_pkg::ST_IDLE:
        if (s_tvalid_i) begin
          case (s_op_i)
            gawu_pkg::OP_PUSH: state_d = gawu_pkg::ST_PUSH_WR;
            gawu_pkg::OP_PULL: state_d = gawu_pkg::ST_PULL_OUT;
            default:           state_d = s_last_i ? gawu_pkg::ST_ACK_OUT : gawu_pkg::ST_IDLE;
          endcase
        end
      gawu_pkg::ST_PUSH_WR:
        if (!sts_i.last) state_d = gawu_pkg::ST_IDLE;
        else if (sts_i.due) state_d = gawu_pkg::ST_NORM_RD;
        else state_d = gawu_pkg::ST_ACK_OUT;
      gawu_pkg::ST_PULL_OUT, gawu_pkg::ST_ACK_OUT:
        if (sts_i.out_free) state_d = gawu_pkg::ST_IDLE;
      gawu_pkg::ST_NORM_RD:
        if (!sts_i.idx_active || sts_i.norm_end) state_d = gawu_pkg::ST_NORM_WAIT;
      gawu_pkg::ST_NORM_WAIT:
        if (!sts_i.pipe_busy) state_d = gawu_pkg::ST_SQRT;
      gawu_pkg::ST_SQRT:
        if (sts_i.sqrt_done) state_d = gawu_pkg::ST_UPD_RD;
      gawu_pkg::ST_UPD_RD:
        state_d = sts_i.idx_active ? gawu_pkg::ST_UPD_MUL : gawu_pkg::ST_UPD_WR;
      gawu_pkg::ST_UPD_MUL:  state_d = gawu_pkg::ST_UPD_RND;
      gawu_pkg::ST_UPD_RND:  state_d = gawu_pkg::ST_UPD_W1;
      gawu_pkg::ST_UPD_W1:
        state_d = sts_i.norm_zero ? gawu_pkg::ST_UPD_WR : gawu_pkg::ST_UPD_LMUL;
      gawu_pkg::ST_UPD_LMUL: state_d = gawu_pkg::ST_UPD_DIVI;
      gawu_pkg::ST_UPD_DIVI: state_d = gawu_pkg::ST_UPD_DIV;
      gawu_pkg::ST_UPD_DIV:
        if (sts_i.div_done) state_d = gawu_pkg::ST_UPD_W2;
      gawu_pkg::ST_UPD_W2:   state_d = gawu_pkg::ST_UPD_WR;
      gawu_pkg::ST_UPD_WR:
        state_d = sts_i.idx_last ? gawu_pkg::ST_ACK_OUT : gawu_pkg::ST_UPD_RD;
      default: state_d = gawu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.rd_sel = gawu_pkg::RD_INDEX;
    s_tready_o   = 1'b0;
    case (state_q)
      gawu_pkg::ST_CLEAR: begin
        cmd_o.clr_wr  = 1'b1;
        cmd_o.idx_inc = !sts_i.idx_last;
        cmd_o.idx_clr = sts_i.idx_last;
      end
      gawu_pkg::ST_IDLE: begin
        s_tready_o   = 1'b1;
        cmd_o.rd_sel = gawu_pkg::RD_INPUT;
        cmd_o.accept = s_tvalid_i;
      end
      gawu_pkg::ST_PUSH_WR: begin
        cmd_o.rd_sel    = gawu_pkg::RD_HELD;
        cmd_o.grad_push = 1'b1;
        cmd_o.cnt_inc   = sts_i.last;
        cmd_o.norm_clr  = sts_i.last && sts_i.due;
        cmd_o.idx_clr   = sts_i.last && sts_i.due;
      end
      gawu_pkg::ST_PULL_OUT: begin
        cmd_o.rd_sel   = gawu_pkg::RD_HELD;
        cmd_o.out_pull = sts_i.out_free;
      end
      gawu_pkg::ST_ACK_OUT: cmd_o.out_ack = sts_i.out_free;
      gawu_pkg::ST_NORM_RD: begin
        cmd_o.norm_issue = sts_i.idx_active;
        cmd_o.idx_inc    = sts_i.idx_active;
      end
      gawu_pkg::ST_NORM_WAIT: begin
        cmd_o.sqrt_start = !sts_i.pipe_busy;
        cmd_o.idx_clr    = !sts_i.pipe_busy;
      end
      gawu_pkg::ST_SQRT:     cmd_o.sqrt_step = 1'b1;
      gawu_pkg::ST_UPD_MUL:  cmd_o.upd_mul   = 1'b1;
      gawu_pkg::ST_UPD_RND:  cmd_o.upd_rnd   = 1'b1;
      gawu_pkg::ST_UPD_W1:   cmd_o.upd_w1    = 1'b1;
      gawu_pkg::ST_UPD_LMUL: cmd_o.upd_lmul  = 1'b1;
      gawu_pkg::ST_UPD_DIVI: cmd_o.div_start = 1'b1;
      gawu_pkg::ST_UPD_DIV:  cmd_o.div_step  = 1'b1;
      gawu_pkg::ST_UPD_W2:   cmd_o.upd_w2    = 1'b1;
      gawu_pkg::ST_UPD_WR: begin
        cmd_o.upd_wr  = 1'b1;
        cmd_o.idx_inc = !sts_i.idx_last;
        cmd_o.cnt_clr = sts_i.idx_last;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* sv/gradient_aggregate_weight_update_core.sv */
// Top level of the gradient aggregation and weight update core.
//
//  channel   | dir | contents
//  s_axis    | in  | tuser: operation; tdata: key [9:0], grad_value [41:10]; tlast: last
//  m_axis    | out | tuser: kind; tdata: out_key [9:0], weight_value [41:10]; tlast: end_of_reply
//  cfg       | in  | write enable, register index, 16-bit data; no read-back
//
// Push and pull read the store, then write it back or load the output register; an ack adds ACK_OUT.
// A completing round runs the update: a pass of squares, the square root, then per entry UPD_RD,
// UPD_MUL, UPD_RND, UPD_W1 and UPD_WR, plus the bit-serial divider states with nonzero norm;
// only UPD_RD and UPD_WR if inactive. After reset a clearing pass writes both stores with
// s_axis_tready low. A held result waits in the output register while the next item is taken.
`timescale 1ns / 1ps
`default_nettype none
module gradient_aggregate_weight_update_core #(
  parameter int MAX_LENGTH = 1024
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [gawu_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // key, grad_value
  input  wire logic [gawu_pkg::OP_W-1:0]         s_axis_tuser,  // operation
  input  wire logic                              s_axis_tlast,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic      [gawu_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // out_key, weight_value
  output logic                                   m_axis_tuser,  // kind
  output logic                                   m_axis_tlast,
  input  wire logic                              cfg_we_i,
  input  wire logic [gawu_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [gawu_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  gawu_pkg::cmd_t cmd;
  gawu_pkg::sts_t sts;

  gawu_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_axis_tvalid),
    .s_tready_o(s_axis_tready),
    .s_op_i    (s_axis_tuser),
    .s_last_i  (s_axis_tlast),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  gawu_dp #(.MAX_LENGTH(MAX_LENGTH)) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .s_tdata_i (s_axis_tdata),
    .s_tlast_i (s_axis_tlast),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .m_tready_i(m_axis_tready),
    .m_tvalid_o(m_axis_tvalid),
    .m_tdata_o (m_axis_tdata),
    .m_tuser_o (m_axis_tuser),
    .m_tlast_o (m_axis_tlast)
  );

endmodule
`default_nettype wire

/* sv/gawu_checker.sv */
// Port-level checker for the core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "gradient_aggregate_weight_update_core_assert.svh"
module gawu_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              s_axis_tvalid,
  input wire logic                              s_axis_tready,
  input wire logic [gawu_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input wire logic [gawu_pkg::OP_W-1:0]         s_axis_tuser,
  input wire logic                              s_axis_tlast,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [gawu_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input wire logic                              m_axis_tuser,
  input wire logic                              m_axis_tlast,
  input wire logic                              cfg_we_i,
  input wire logic [gawu_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input wire logic [gawu_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  `GAWU_ASSERT_PROP(a_out_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)), "result dropped or changed while stalled")
  `GAWU_ASSERT_NEVER(a_ack_form, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser == gawu_pkg::KIND_ACK) && (m_axis_tdata != '0 || !m_axis_tlast), "malformed acknowledgement")
  // an initialize element that is not last needs no further work
  `GAWU_ASSERT_PROP(a_one_item, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready && (s_axis_tuser == gawu_pkg::OP_PUSH || s_axis_tuser == gawu_pkg::OP_PULL || s_axis_tlast)) |=> !s_axis_tready, "second transaction taken before first was processed")
  `GAWU_ASSERT_PROP(a_clear_pass, clk_i, rst_ni, $rose(rst_ni) |-> !s_axis_tready, "input taken during clearing pass")

endmodule

bind gradient_aggregate_weight_update_core gawu_checker u_gawu_checker (.*);
`default_nettype wire
